/* rtl/homogeneous_point_transform_assert.svh */
// Assertion macros used by the checker file.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_ASSERT_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_ASSERT_SVH

// Condition a implies condition b in the same cycle.
`define HPT_ASSERT_IMPL(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("hpt assertion failed");

// Condition a implies condition b in the next cycle.
`define HPT_ASSERT_NEXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("hpt assertion failed");

`endif

/* rtl/hpt_pkg.sv */
package hpt_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int SUM_W     = PROD_W + 2;          // four terms, exact
  localparam int MAG_W     = SUM_W;               // |sum| fits unsigned
  localparam int NUM_W     = MAG_W + FRAC_BITS;   // |t| << FRAC_BITS
  localparam int QUO_W     = COORD_W;
  localparam int N_STAGES  = QUO_W;               // one quotient bit per stage
  localparam int CFG_W     = 64;
  localparam int N_REGS    = 8;
  localparam int REG_IDX_W = $clog2(N_REGS);
  localparam int CFG_IDX_W = 8;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);

  localparam logic [CFG_W-1:0] ONE_LO = CFG_W'(1) << FRAC_BITS;
  localparam logic [CFG_W-1:0] ONE_HI = ONE_LO << COORD_W;

  localparam logic [QUO_W-1:0] SAT_POS = {1'b0, {(QUO_W-1){1'b1}}};
  localparam logic [QUO_W-1:0] SAT_NEG = {1'b1, {(QUO_W-1){1'b0}}};

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROW0_LO, REG_ROW0_HI, REG_ROW1_LO, REG_ROW1_HI,
    REG_ROW2_LO, REG_ROW2_HI, REG_ROW3_LO, REG_ROW3_HI
  } reg_idx_e;

  // Column sums t0..t2 and w (index 3), two's complement.
  typedef struct packed {
    logic [3:0][SUM_W-1:0] t;
  } item_t;

endpackage

/* rtl/homogeneous_point_transform.sv */
// Homogeneous point transform: (px, py, pz, 1) times a 4x4 Q16.16 matrix,
// then t0..t2 divided by w with truncation toward zero and saturation.
// Input queue side: drive px_i/py_i/pz_i with push high; a request is
// taken at a clock edge where full is low. Result side: a result sits on
// qx_o/qy_o/qz_o/w_zero_o/clipped_o while empty is low; pop takes it.
// Matrix registers are written on cfg_valid_i/cfg_ready_o (always ready),
// cfg_index_i 0..7 per row half; other indexes are dropped. Write only
// while the block is idle.
// Throughput: one point per cycle while pop keeps up. A point passes the
// 3-stage multiply/sum front, the 4-entry queue, and the 32-stage
// restoring divider with one quotient bit a stage before empty goes low.
// If pop stays low the back pipeline holds; the front keeps taking up to
// four more points into the queue plus its own stages, then raises full.
// Reset loads the identity matrix and empties all stages.
module homogeneous_point_transform import hpt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 push,
  output logic                 full,
  input  logic [COORD_W-1:0]   px_i,
  input  logic [COORD_W-1:0]   py_i,
  input  logic [COORD_W-1:0]   pz_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [QUO_W-1:0]     qx_o,
  output logic [QUO_W-1:0]     qy_o,
  output logic [QUO_W-1:0]     qz_o,
  output logic                 w_zero_o,
  output logic                 clipped_o
);

  logic  in_ready, f_valid, q_full, q_empty, q_pop, b_valid;
  item_t f_item, q_item;

  assign cfg_ready_o = 1'b1;
  assign full        = !in_ready;
  assign empty       = !b_valid;

  hpt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (push),
    .in_ready_o  (in_ready),
    .px_i        (px_i),
    .py_i        (py_i),
    .pz_i        (pz_i),
    .out_valid_o (f_valid),
    .out_item_o  (f_item),
    .out_full_i  (q_full)
  );

  hpt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .item_i  (f_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (q_item),
    .empty_o (q_empty)
  );

  hpt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (!q_empty),
    .in_item_i   (q_item),
    .in_pop_o    (q_pop),
    .out_valid_o (b_valid),
    .out_pop_i   (pop),
    .qx_o        (qx_o),
    .qy_o        (qy_o),
    .qz_o        (qz_o),
    .w_zero_o    (w_zero_o),
    .clipped_o   (clipped_o)
  );

endmodule

/* rtl/hpt_front.sv */
module hpt_front import hpt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [COORD_W-1:0]   px_i,
  input  logic [COORD_W-1:0]   py_i,
  input  logic [COORD_W-1:0]   pz_i,
  output logic                 out_valid_o,
  output item_t                out_item_o,
  input  logic                 out_full_i
);

  logic [CFG_W-1:0] cfg_q [N_REGS];
  logic signed [COORD_W-1:0] m [4][4];

  logic en;
  logic v1_q, v2_q, v3_q;
  logic signed [COORD_W-1:0] p1_q [3];
  logic signed [PROD_W-1:0]  prod_q [3][4];
  logic signed [PROD_W-1:0]  trans_q [4];
  item_t item_q;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        m[r][c] = cfg_q[r*2 + c/2][(c%2)*COORD_W +: COORD_W];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[REG_ROW0_LO] <= ONE_LO;
      cfg_q[REG_ROW0_HI] <= '0;
      cfg_q[REG_ROW1_LO] <= ONE_HI;
      cfg_q[REG_ROW1_HI] <= '0;
      cfg_q[REG_ROW2_LO] <= '0;
      cfg_q[REG_ROW2_HI] <= ONE_LO;
      cfg_q[REG_ROW3_LO] <= '0;
      cfg_q[REG_ROW3_HI] <= ONE_HI;
    end else if (cfg_valid_i && (cfg_index_i < CFG_IDX_W'(N_REGS))) begin
      cfg_q[cfg_index_i[REG_IDX_W-1:0]] <= cfg_data_i;
    end
  end

  // The whole front holds while its last stage waits on a full queue.
  assign en         = !v3_q || !out_full_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q[0] <= px_i;
      p1_q[1] <= py_i;
      p1_q[2] <= pz_i;
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 3; r++) begin
          prod_q[r][c] <= p1_q[r] * m[r][c];
        end
        trans_q[c] <= PROD_W'(m[3][c]) <<< FRAC_BITS;
        item_q.t[c] <= SUM_W'(prod_q[0][c]) + SUM_W'(prod_q[1][c])
                     + SUM_W'(prod_q[2][c]) + SUM_W'(trans_q[c]);
      end
    end
  end

  assign out_valid_o = v3_q;
  assign out_item_o  = item_q;

endmodule

/* rtl/hpt_queue.sv */
module hpt_queue import hpt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o
);

  item_t mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, rd_q;
  logic [Q_PTR_W:0]   cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == (Q_PTR_W+1)'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= item_i;
  end

endmodule

/* rtl/hpt_back.sv */
module hpt_back import hpt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  item_t              in_item_i,
  output logic               in_pop_o,
  output logic               out_valid_o,
  input  logic               out_pop_i,
  output logic [QUO_W-1:0]   qx_o,
  output logic [QUO_W-1:0]   qy_o,
  output logic [QUO_W-1:0]   qz_o,
  output logic               w_zero_o,
  output logic               clipped_o
);

  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [QUO_W-1:0] low;
    logic [QUO_W-1:0] quo;
    logic             ovf;
    logic             neg;
  } lane_t;

  typedef struct packed {
    lane_t [2:0]      lane;
    logic [MAG_W-1:0] d;
    logic             wz;
  } stage_t;

  function automatic lane_t div_step(lane_t l, logic [MAG_W-1:0] d);
    logic [MAG_W:0] t;
    logic           ge;
    lane_t          r;
    t  = {l.rem, l.low[QUO_W-1]};
    ge = (t >= {1'b0, d});
    r  = l;
    r.rem = ge ? MAG_W'(t - {1'b0, d}) : t[MAG_W-1:0];
    r.low = l.low << 1;
    r.quo = {l.quo[QUO_W-2:0], ge};
    return r;
  endfunction

  logic en;
  logic b0v_q, b1v_q, ov_q;
  item_t b0_q;
  logic [MAG_W-1:0] nmag_q [3];
  logic [2:0]       nneg_q;
  logic [MAG_W-1:0] dmag_q;
  logic             dneg_q, wz_q;

  logic   sv_q [N_STAGES+1];
  stage_t s_q  [N_STAGES+1];
  stage_t s_d  [N_STAGES+1];

  logic [QUO_W-1:0] res_d [3];
  logic             clip_d;
  logic [QUO_W-1:0] res_q [3];
  logic             wzo_q, clip_q;

  // Back pipeline moves as one unit, held only by a waiting result.
  assign en       = !ov_q || out_pop_i;
  assign in_pop_o = en && in_valid_i;

  always_comb begin
    logic [NUM_W-1:0] n;
    n = '0;
    s_d[0].d  = dmag_q;
    s_d[0].wz = wz_q;
    for (int c = 0; c < 3; c++) begin
      n = {nmag_q[c], {FRAC_BITS{1'b0}}};
      s_d[0].lane[c].rem = MAG_W'(n[NUM_W-1:QUO_W]);
      s_d[0].lane[c].low = n[QUO_W-1:0];
      s_d[0].lane[c].quo = '0;
      s_d[0].lane[c].ovf = (MAG_W'(n[NUM_W-1:QUO_W]) >= dmag_q);
      s_d[0].lane[c].neg = nneg_q[c] ^ dneg_q;
    end
    for (int k = 0; k < N_STAGES; k++) begin
      s_d[k+1] = s_q[k];
      for (int c = 0; c < 3; c++) begin
        s_d[k+1].lane[c] = div_step(s_q[k].lane[c], s_q[k].d);
      end
    end
  end

  always_comb begin
    logic [QUO_W-1:0] lim, mag;
    logic             sat;
    lim    = '0;
    mag    = '0;
    sat    = 1'b0;
    clip_d = 1'b0;
    for (int c = 0; c < 3; c++) begin
      lim = s_q[N_STAGES].lane[c].neg ? SAT_NEG : SAT_POS;
      sat = s_q[N_STAGES].lane[c].ovf || (s_q[N_STAGES].lane[c].quo > lim);
      mag = sat ? lim : s_q[N_STAGES].lane[c].quo;
      res_d[c] = s_q[N_STAGES].wz ? '0
               : (s_q[N_STAGES].lane[c].neg ? (~mag + 1'b1) : mag);
      clip_d = clip_d | (sat && !s_q[N_STAGES].wz);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0v_q <= 1'b0;
      b1v_q <= 1'b0;
      ov_q  <= 1'b0;
      for (int k = 0; k <= N_STAGES; k++) sv_q[k] <= 1'b0;
    end else if (en) begin
      b0v_q   <= in_valid_i;
      b1v_q   <= b0v_q;
      sv_q[0] <= b1v_q;
      for (int k = 0; k < N_STAGES; k++) sv_q[k+1] <= sv_q[k];
      ov_q    <= sv_q[N_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b0_q <= in_item_i;
      for (int c = 0; c < 3; c++) begin
        nneg_q[c] <= b0_q.t[c][SUM_W-1];
        nmag_q[c] <= b0_q.t[c][SUM_W-1] ? (~b0_q.t[c] + 1'b1) : b0_q.t[c];
      end
      dneg_q <= b0_q.t[3][SUM_W-1];
      dmag_q <= b0_q.t[3][SUM_W-1] ? (~b0_q.t[3] + 1'b1) : b0_q.t[3];
      wz_q   <= (b0_q.t[3] == '0);
      for (int k = 0; k <= N_STAGES; k++) s_q[k] <= s_d[k];
      for (int c = 0; c < 3; c++) res_q[c] <= res_d[c];
      wzo_q  <= s_q[N_STAGES].wz;
      clip_q <= clip_d;
    end
  end

  assign out_valid_o = ov_q;
  assign qx_o        = res_q[0];
  assign qy_o        = res_q[1];
  assign qz_o        = res_q[2];
  assign w_zero_o    = wzo_q;
  assign clipped_o   = clip_q;

endmodule

/* rtl/hpt_checker.sv */
`include "homogeneous_point_transform_assert.svh"

module hpt_checker import hpt_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_o,
  input logic [CFG_IDX_W-1:0] cfg_index_i,
  input logic [CFG_W-1:0]     cfg_data_i,
  input logic                 push,
  input logic                 full,
  input logic [COORD_W-1:0]   px_i,
  input logic [COORD_W-1:0]   py_i,
  input logic [COORD_W-1:0]   pz_i,
  input logic                 empty,
  input logic                 pop,
  input logic [QUO_W-1:0]     qx_o,
  input logic [QUO_W-1:0]     qy_o,
  input logic [QUO_W-1:0]     qz_o,
  input logic                 w_zero_o,
  input logic                 clipped_o
);

  // zero w gives zero coordinates and no clip
  `HPT_ASSERT_IMPL(a_wzero_zeros, clk_i, rst_ni, !empty && w_zero_o,
    qx_o == '0 && qy_o == '0 && qz_o == '0 && !clipped_o)

  // a clipped coordinate is one of the saturation values
  `HPT_ASSERT_IMPL(a_clip_value, clk_i, rst_ni, !empty && clipped_o,
    qx_o == SAT_POS || qx_o == SAT_NEG || qy_o == SAT_POS ||
    qy_o == SAT_NEG || qz_o == SAT_POS || qz_o == SAT_NEG)

  // a stalled result holds
  `HPT_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, !empty && !pop,
    !empty && $stable(qx_o) && $stable(qy_o) && $stable(qz_o) &&
    $stable(w_zero_o) && $stable(clipped_o))

endmodule

bind homogeneous_point_transform hpt_checker u_hpt_checker (.*);

/* tb/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hpt_pkg::*;

  localparam int  IDLE_LIMIT  = 5000;
  localparam int  DRAIN_WAIT  = 50;
  localparam int  N_PHASES    = 10;
  localparam int  PHASE_ITEMS = 125;
  localparam logic signed [127:0] Q_MAX = 128'sd2147483647;
  localparam logic signed [127:0] Q_MIN = -128'sd2147483648;

  typedef struct packed {
    logic [2:0][QUO_W-1:0] q;
    logic                  wz;
    logic                  clip;
  } vtx_res_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    logic [COORD_W-1:0]   px, py, pz;
    bit                   typed;
    vtx_res_t             res;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 push = 1'b0;
  logic                 full;
  logic [COORD_W-1:0]   px_i = '0, py_i = '0, pz_i = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [QUO_W-1:0]     qx_o, qy_o, qz_o;
  logic                 w_zero_o, clipped_o;

  logic [CFG_W-1:0] mat_reg [N_REGS];
  vtx_res_t         pend_res = '0;
  vtx_res_t         vtx_exp_q [$];
  dir_row_t         dir_tab [$];
  int               n_err = 0;
  int               burst_left = 0;
  int               idle_cnt = 0;

  homogeneous_point_transform u_top (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .push, .full, .px_i, .py_i, .pz_i, .empty, .pop,
    .qx_o, .qy_o, .qz_o, .w_zero_o, .clipped_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic signed [127:0] mat_entry(int r, int c);
    logic [CFG_W-1:0]          rv;
    logic signed [COORD_W-1:0] h;
    logic signed [127:0]       e;
    rv = mat_reg[r * 2 + c / 2];
    h  = (c % 2) ? rv[63:32] : rv[31:0];
    e  = h;
    return e;
  endfunction

  function automatic vtx_res_t predict_vertex(logic [COORD_W-1:0] x, y, z);
    logic signed [COORD_W-1:0] xs, ys, zs;
    logic signed [127:0]       p0, p1, p2, qv;
    logic signed [127:0]       t [4];
    vtx_res_t                  r;
    xs = x; ys = y; zs = z;
    p0 = xs; p1 = ys; p2 = zs;
    r  = '0;
    for (int c = 0; c < 4; c++)
      t[c] = p0 * mat_entry(0, c) + p1 * mat_entry(1, c) + p2 * mat_entry(2, c)
           + (mat_entry(3, c) <<< FRAC_BITS);
    if (t[3] == 0) begin
      r.wz = 1'b1;
    end else begin
      for (int c = 0; c < 3; c++) begin
        qv = (t[c] <<< FRAC_BITS) / t[3];
        if (qv > Q_MAX) begin
          r.q[c] = SAT_POS;
          r.clip = 1'b1;
        end else if (qv < Q_MIN) begin
          r.q[c] = SAT_NEG;
          r.clip = 1'b1;
        end else begin
          r.q[c] = qv[QUO_W-1:0];
        end
      end
    end
    return r;
  endfunction

  task automatic report(string what, logic [QUO_W-1:0] got, logic [QUO_W-1:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    n_err++;
  endtask

  // Wait until every issued point has come back, then let the pipe settle.
  task automatic drain_pipe();
    push <= 1'b0;
    @(posedge clk_i);
    while (vtx_exp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx < N_REGS) mat_reg[idx] = data;
    @(posedge clk_i);
  endtask

  task automatic send_point(logic [COORD_W-1:0] x, y, z, bit typed, vtx_res_t res);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    push     <= 1'b1;
    px_i     <= x;
    py_i     <= y;
    pz_i     <= z;
    pend_res <= typed ? res : predict_vertex(x, y, z);
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    burst_left--;
  endtask

  function automatic vtx_res_t mk_res(logic [QUO_W-1:0] a, b, c, logic wz, clip);
    vtx_res_t r;
    r.q[0] = a; r.q[1] = b; r.q[2] = c; r.wz = wz; r.clip = clip;
    return r;
  endfunction

  function automatic dir_row_t pt(logic [COORD_W-1:0] x, y, z, bit typed = 0,
                                  vtx_res_t res = '0);
    dir_row_t d;
    d = '{is_cfg: 0, idx: '0, data: '0, px: x, py: y, pz: z, typed: typed, res: res};
    return d;
  endfunction

  function automatic dir_row_t cf(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    dir_row_t d;
    d = '{is_cfg: 1, idx: idx, data: data, px: '0, py: '0, pz: '0, typed: 0, res: '0};
    return d;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 19))
      0, 1, 2:  return SAT_NEG | $urandom_range(0, 1);
      3, 4, 5:  return SAT_POS - $urandom_range(0, 1);
      6, 7, 8:  return COORD_W'($signed($urandom_range(0, 7)) - 4);
      9, 10, 11, 12, 13, 14: return COORD_W'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      default:  return $urandom;
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] rand_entry(int mode, bit wcol);
    logic [COORD_W-1:0] ex [5];
    ex = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0001_0000};
    case (mode)
      0: return $urandom;
      1: return COORD_W'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      2: return ex[$urandom_range(0, 4)];
      3: return wcol ? '0 : $urandom;
      default: return wcol ? COORD_W'($signed($urandom_range(0, 4)) - 2)
                           : COORD_W'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (push && !full) vtx_exp_q.push_back(pend_res);
  end

  always @(posedge clk_i) begin
    vtx_res_t e;
    if (pop && !empty) begin
      if (vtx_exp_q.size() == 0) begin
        report("unexpected qx", qx_o, '0);
      end else begin
        e = vtx_exp_q.pop_front();
        if (qx_o !== e.q[0])     report("qx", qx_o, e.q[0]);
        if (qy_o !== e.q[1])     report("qy", qy_o, e.q[1]);
        if (qz_o !== e.q[2])     report("qz", qz_o, e.q[2]);
        if (w_zero_o !== e.wz)   report("w_zero", 32'(w_zero_o), 32'(e.wz));
        if (clipped_o !== e.clip) report("clipped", 32'(clipped_o), 32'(e.clip));
      end
    end
  end

  // Receiver: segments of free flow, random pops, sparse pops and hard stalls.
  int pop_mode = 0, pop_left = 0;
  always @(posedge clk_i) begin
    if (pop_left == 0) begin
      pop_mode = $urandom_range(0, 3);
      pop_left = (pop_mode == 3) ? $urandom_range(1, 40) : $urandom_range(20, 200);
    end
    pop_left--;
    case (pop_mode)
      0:       pop <= 1'b1;
      1:       pop <= $urandom_range(0, 1);
      2:       pop <= ($urandom_range(0, 3) == 0);
      default: pop <= 1'b0;
    endcase
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("** homogeneous_point_transform: FAILED **");
      $finish;
    end
  end

  initial begin
    int mode;
    mat_reg = '{ONE_LO, '0, ONE_HI, '0, '0, ONE_LO, '0, ONE_HI};

    // identity after reset: output equals input
    dir_tab.push_back(pt(32'h0, 32'h0, 32'h0, 1, mk_res(0, 0, 0, 0, 0)));
    dir_tab.push_back(pt(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 1,
                         mk_res(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 0, 0)));
    dir_tab.push_back(pt(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1,
                         mk_res(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0)));
    dir_tab.push_back(pt(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 1,
                         mk_res(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 0, 0)));
    dir_tab.push_back(pt(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
    // w forced to zero
    dir_tab.push_back(cf(REG_ROW3_HI, 64'h0));
    dir_tab.push_back(pt(32'h7FFF_FFFF, 32'h8000_0000, 32'h12345, 1, mk_res(0, 0, 0, 1, 0)));
    dir_tab.push_back(pt(32'h0, 32'h0, 32'h0, 1, mk_res(0, 0, 0, 1, 0)));
    // tiny w: quotients overflow both ways
    dir_tab.push_back(cf(REG_ROW3_HI, 64'h0000_0001_0000_0000));
    dir_tab.push_back(pt(32'h0001_0000, 32'h0, 32'hFFFF_0000, 1,
                         mk_res(SAT_POS, 32'h0, SAT_NEG, 0, 1)));
    dir_tab.push_back(pt(32'h1, 32'hFFFF_FFFF, 32'h0));
    // negative w: sign flips, most negative input clips
    dir_tab.push_back(cf(REG_ROW3_HI, 64'hFFFF_0000_0000_0000));
    dir_tab.push_back(pt(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1,
                         mk_res(32'hFFFF_0000, 32'hFFFE_0000, 32'hFFFD_0000, 0, 0)));
    dir_tab.push_back(pt(32'h8000_0000, 32'h0, 32'h0, 1, mk_res(SAT_POS, 0, 0, 0, 1)));
    // out-of-range indexes are dropped
    dir_tab.push_back(cf(CFG_IDX_W'(N_REGS), 64'hDEAD_BEEF_0123_4567));
    dir_tab.push_back(cf(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF));
    dir_tab.push_back(pt(32'h0003_8000, 32'hFFF0_0000, 32'h7FFF_FFFF));
    dir_tab.push_back(cf(REG_ROW0_HI, 64'h0000_8000_0000_4000));
    dir_tab.push_back(pt(32'h0002_0000, 32'hFFFF_8000, 32'h0001_0000));
    dir_tab.push_back(pt(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        drain_pipe();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_point(dir_tab[i].px, dir_tab[i].py, dir_tab[i].pz,
                   dir_tab[i].typed, dir_tab[i].res);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      mode = (ph < 5) ? ph : $urandom_range(0, 4);
      drain_pipe();
      for (int r = 0; r < N_REGS; r++)
        write_reg(CFG_IDX_W'(r), {rand_entry(mode, r[0]), rand_entry(mode, 0)});
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_IDX_W'($urandom_range(N_REGS, 255)), {$urandom, $urandom});
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_point(rand_coord(), rand_coord(), rand_coord(), 0, '0);
    end

    drain_pipe();
    if (n_err == 0) begin
      $display("** homogeneous_point_transform: PASSED **");
    end else begin
      $display("** homogeneous_point_transform: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/hpt_pkg.sv
rtl/hpt_front.sv
rtl/hpt_queue.sv
rtl/hpt_back.sv
rtl/homogeneous_point_transform.sv
rtl/hpt_checker.sv
tb/tb_top.sv
